@@ rtl/bvs_pkg.sv @@
// Package for the bencode value skipper: scan mode codes, byte roles,
// fault codes, character constants and the result record.
// No dependencies.
package bvs_pkg;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_ELEM = 5'b00010,
    MODE_LEN  = 5'b00100,
    MODE_STR  = 5'b01000,
    MODE_INT  = 5'b10000
  } mode_t;

  localparam logic [2:0] ROLE_OPEN  = 3'd0;
  localparam logic [2:0] ROLE_CLOSE = 3'd1;
  localparam logic [2:0] ROLE_DIGIT = 3'd2;
  localparam logic [2:0] ROLE_SEP   = 3'd3;
  localparam logic [2:0] ROLE_STR   = 3'd4;
  localparam logic [2:0] ROLE_INT   = 3'd5;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DEPTH = 2'd1;
  localparam logic [1:0] FAULT_LEN   = 2'd2;
  localparam logic [1:0] FAULT_NUL   = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_E    = 8'h65;
  localparam logic [7:0] CHAR_I    = 8'h69;
  localparam logic [7:0] CHAR_L    = 8'h6C;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  typedef struct packed {
    logic       value_done;
    logic [6:0] nest_level;
    logic [2:0] byte_role;
    logic [1:0] fault;
  } result_t;

endpackage

@@ rtl/bvs_in_if.sv @@
// Byte channel of the bencode value skipper: valid/ready plus one byte.
// No dependencies.
interface bvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

@@ rtl/bvs_out_if.sv @@
// Result channel of the bencode value skipper: valid/ready plus the
// per-byte classification fields.
// No dependencies.
interface bvs_out_if;
  logic       valid;
  logic       ready;
  logic       value_done;
  logic [6:0] nest_level;
  logic [2:0] byte_role;
  logic [1:0] fault;

  modport source (output valid, output value_done, output nest_level,
                  output byte_role, output fault, input ready);
  modport sink (input valid, input value_done, input nest_level,
                input byte_role, input fault, output ready);
endinterface

@@ rtl/bvs_step.sv @@
// Next-state and result logic for one byte of the bencode scan.
// Depends on bvs_pkg.
module bvs_step #(
  parameter int CW = 7,
  parameter int LB = 32,
  parameter int DEPTH_MAX = 64
) (
  input  bvs_pkg::mode_t   mode,
  input  logic [CW-1:0]    count,
  input  logic [LB-1:0]    left,
  input  logic [7:0]       byte_in,
  output bvs_pkg::mode_t   mode_next,
  output logic [CW-1:0]    count_next,
  output logic [LB-1:0]    left_next,
  output bvs_pkg::result_t result
);

  localparam logic [CW-1:0] DEPTH_LIM = CW'(DEPTH_MAX);

  logic          dec_byte;
  logic [3:0]    digit;
  logic [LB+3:0] left_ext;
  logic [LB+3:0] left_x10;
  logic          len_sat;
  logic [CW-1:0] count_dec;

  assign dec_byte  = (byte_in >= bvs_pkg::CHAR_ZERO) && (byte_in <= bvs_pkg::CHAR_NINE);
  assign digit     = 4'(byte_in - bvs_pkg::CHAR_ZERO);
  assign left_ext  = {4'b0, left};
  // 10*left + digit; saturate when it no longer fits in LB bits
  assign left_x10  = (left_ext << 3) + (left_ext << 1) + {{LB{1'b0}}, digit};
  assign len_sat   = |left_x10[LB+3:LB];
  assign count_dec = (count != '0) ? count - CW'(1) : count;

  always_comb begin
    mode_next         = mode;
    count_next        = count;
    left_next         = left;
    result.value_done = 1'b0;
    result.byte_role  = bvs_pkg::ROLE_OPEN;
    result.fault      = bvs_pkg::FAULT_NONE;
    case (mode)
      bvs_pkg::MODE_ELEM: begin
        if (byte_in == bvs_pkg::CHAR_NUL) begin
          result.byte_role  = bvs_pkg::ROLE_CLOSE;
          result.fault      = bvs_pkg::FAULT_NUL;
          result.value_done = 1'b1;
          count_next        = '0;
          mode_next         = bvs_pkg::MODE_IDLE;
        end else if (byte_in == bvs_pkg::CHAR_E) begin
          result.byte_role = bvs_pkg::ROLE_CLOSE;
          count_next       = count_dec;
          if (count_dec == '0) begin
            result.value_done = 1'b1;
            mode_next         = bvs_pkg::MODE_IDLE;
          end
        end else if (dec_byte) begin
          result.byte_role = bvs_pkg::ROLE_DIGIT;
          left_next        = {{(LB-4){1'b0}}, digit};
          mode_next        = bvs_pkg::MODE_LEN;
        end else if (byte_in == bvs_pkg::CHAR_I) begin
          result.byte_role = bvs_pkg::ROLE_INT;
          mode_next        = bvs_pkg::MODE_INT;
        end else begin
          // 'l', 'd' and anything else open a container
          result.byte_role = bvs_pkg::ROLE_OPEN;
          if (count >= DEPTH_LIM) begin
            result.fault      = bvs_pkg::FAULT_DEPTH;
            result.value_done = 1'b1;
            count_next        = '0;
            mode_next         = bvs_pkg::MODE_IDLE;
          end else begin
            count_next = count + CW'(1);
          end
        end
      end
      bvs_pkg::MODE_LEN: begin
        if (dec_byte) begin
          result.byte_role = bvs_pkg::ROLE_DIGIT;
          if (len_sat) begin
            left_next    = '1;
            result.fault = bvs_pkg::FAULT_LEN;
          end else begin
            left_next = left_x10[LB-1:0];
          end
        end else begin
          result.byte_role = bvs_pkg::ROLE_SEP;
          mode_next = (left == '0) ? bvs_pkg::MODE_ELEM : bvs_pkg::MODE_STR;
        end
      end
      bvs_pkg::MODE_STR: begin
        result.byte_role = bvs_pkg::ROLE_STR;
        left_next        = (left != '0) ? left - LB'(1) : left;
        if (left_next == '0) begin
          mode_next = bvs_pkg::MODE_ELEM;
        end
      end
      bvs_pkg::MODE_INT: begin
        result.byte_role = bvs_pkg::ROLE_INT;
        if (byte_in == bvs_pkg::CHAR_E) begin
          mode_next = bvs_pkg::MODE_ELEM;
        end
      end
      default: begin
        // first byte after idle opens the outer container
        result.byte_role = bvs_pkg::ROLE_OPEN;
        count_next       = CW'(1);
        left_next        = '0;
        mode_next        = bvs_pkg::MODE_ELEM;
      end
    endcase
    // report the level in 7 bits
    result.nest_level = 7'(count_next);
  end

endmodule

@@ rtl/bencode_value_skipper_core.sv @@
// Top level of the bencode value skipper: input byte register, scan
// state, result register and checks. Depends on bvs_pkg, bvs_in_if,
// bvs_out_if and bvs_step.

// Scans a bencoded byte stream one byte per cycle and returns one result
// per byte: its role (open, close, length digit, separator, string byte,
// integer byte), the nesting level after it, a done flag on the byte that
// closes the outermost container or stops the scan, and a fault code
// (nesting overflow past DEPTH_MAX, string length saturated at
// 2^LEN_BITS-1, or NUL at an element start). The first byte taken while
// idle always opens the outer container. Throughput is one byte per
// cycle while result ready stays high; each byte passes an input
// register and then the scan step into the result register, and a low
// result ready holds the result register and a full input register.
// The step reads and writes the scan state in the same cycle. Input
// ready follows result ready combinationally: a byte is taken whenever
// the input register is empty or moves on in the same cycle.
module bencode_value_skipper_core #(
  parameter int DEPTH_MAX = 64,
  parameter int LEN_BITS  = 32
) (
  input  logic            clk,
  input  logic            rst,
  bvs_in_if.sink          byte_chan,
  bvs_out_if.source       result_chan
);

  localparam int CW = $clog2(DEPTH_MAX + 1);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // scan state
  bvs_pkg::mode_t mode;
  logic [CW-1:0]  count;
  logic [LEN_BITS-1:0] left;

  // step outputs
  bvs_pkg::mode_t      mode_next;
  logic [CW-1:0]       count_next;
  logic [LEN_BITS-1:0] left_next;
  bvs_pkg::result_t    step_result;

  // result register
  logic             out_valid;
  bvs_pkg::result_t out_q;

  logic step_fire;
  logic in_take;

  // advance a byte through the step when the result slot is free or drains
  assign step_fire       = in_valid && (!out_valid || result_chan.ready);
  assign byte_chan.ready = !in_valid || step_fire;
  assign in_take         = byte_chan.valid && byte_chan.ready;

  bvs_step #(
    .CW(CW),
    .LB(LEN_BITS),
    .DEPTH_MAX(DEPTH_MAX)
  ) u_step (
    .mode(mode),
    .count(count),
    .left(left),
    .byte_in(in_byte),
    .mode_next(mode_next),
    .count_next(count_next),
    .left_next(left_next),
    .result(step_result)
  );

  // hold the accepted byte until the step consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (step_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= byte_chan.byte_in;
    end
  end

  // commit scan state only when a byte actually moves through the step
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= bvs_pkg::MODE_IDLE;
      count <= '0;
      left  <= '0;
    end else if (step_fire) begin
      mode  <= mode_next;
      count <= count_next;
      left  <= left_next;
    end
  end

  // result register: load on step, drop once the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_q <= step_result;
    end
  end

  assign result_chan.valid      = out_valid;
  assign result_chan.value_done = out_q.value_done;
  assign result_chan.nest_level = out_q.nest_level;
  assign result_chan.byte_role  = out_q.byte_role;
  assign result_chan.fault      = out_q.fault;

  // idle always means no container is open
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (mode == bvs_pkg::MODE_IDLE) |-> (count == '0))
    else $error("open count nonzero while idle");

  // string mode always has bytes left to skip
  a_str_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode == bvs_pkg::MODE_STR) |-> (left != '0))
    else $error("string mode with zero bytes left");

  // a finished value leaves no container open
  a_done_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.value_done) |-> (out_q.nest_level == 7'd0))
    else $error("value done with open containers");

  // length saturation is only reported on a length digit
  a_sat_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.fault == bvs_pkg::FAULT_LEN) |->
      (out_q.byte_role == bvs_pkg::ROLE_DIGIT))
    else $error("length fault on a non-digit byte");

endmodule

@@ sim/testbench.sv @@
// Testbench for bencode_value_skipper_core: drives a bencoded byte stream with random gaps
// and stalls, and checks every per-byte result against a local scan model.
// Depends on bvs_pkg, bvs_in_if, bvs_out_if and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH_MAX  = 64;
  localparam int          LEN_BITS   = 32;
  localparam logic [63:0] LEN_MAX    = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_D     = 8'h64;
  localparam int          RANDOM_BYTES = 1000;
  localparam int          HOLD_AT    = 400;     // result count that triggers the long hold-off
  localparam int          HOLD_LEN   = 60;      // cycles of the long hold-off
  localparam int          CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Source side registers, driven at the falling edge.
  logic       src_valid = 1'b0;
  logic [7:0] src_byte  = 8'h00;
  logic       nxt_valid;
  int         src_gap = 0;
  logic       byte_taken = 1'b0;

  // Sink side registers.
  logic sink_ready = 1'b0;
  int   sink_stall = 0;
  int   sink_hold  = 0;
  logic res_taken  = 1'b0;

  // Byte stream still to send and the verdicts the scan model has produced.
  logic [7:0]       stream_q [$];
  bvs_pkg::result_t byte_verdicts [$];
  bvs_pkg::result_t want;

  int bytes_sent    = 0;
  int verdicts_seen = 0;
  int errors        = 0;
  int cycles        = 0;

  // Scan model state.
  bvs_pkg::mode_t scan_mode;
  int             open_cnt;
  logic [63:0]    len_left;

  bvs_in_if  byte_chan ();
  bvs_out_if result_chan ();

  assign byte_chan.valid    = src_valid;
  assign byte_chan.byte_in  = src_byte;
  assign result_chan.ready  = sink_ready;

  bencode_value_skipper_core #(
    .DEPTH_MAX (DEPTH_MAX),
    .LEN_BITS  (LEN_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .byte_chan   (byte_chan),
    .result_chan (result_chan)
  );

  always #5 clk = ~clk;

  // Advance the scan model by one byte and queue the verdict it gives.
  function automatic void scan_byte(input logic [7:0] b);
    bvs_pkg::result_t r;
    logic [63:0]      d;
    logic             dec_byte;
    r = '0;
    r.byte_role = bvs_pkg::ROLE_OPEN;
    r.fault     = bvs_pkg::FAULT_NONE;
    d = {56'd0, b - bvs_pkg::CHAR_ZERO};
    dec_byte = (b >= bvs_pkg::CHAR_ZERO) && (b <= bvs_pkg::CHAR_NINE);
    case (scan_mode)
      bvs_pkg::MODE_ELEM: begin
        if (b == bvs_pkg::CHAR_NUL) begin
          // NUL where an element should start: abort the whole scan.
          r.byte_role  = bvs_pkg::ROLE_CLOSE;
          r.fault      = bvs_pkg::FAULT_NUL;
          r.value_done = 1'b1;
          open_cnt     = 0;
          scan_mode    = bvs_pkg::MODE_IDLE;
        end else if (b == bvs_pkg::CHAR_E) begin
          r.byte_role = bvs_pkg::ROLE_CLOSE;
          if (open_cnt > 0) open_cnt--;
          if (open_cnt == 0) begin
            r.value_done = 1'b1;
            scan_mode    = bvs_pkg::MODE_IDLE;
          end
        end else if (dec_byte) begin
          r.byte_role = bvs_pkg::ROLE_DIGIT;
          len_left    = d;
          scan_mode   = bvs_pkg::MODE_LEN;
        end else if (b == bvs_pkg::CHAR_I) begin
          r.byte_role = bvs_pkg::ROLE_INT;
          scan_mode   = bvs_pkg::MODE_INT;
        end else if (open_cnt >= DEPTH_MAX) begin
          // One open too many: flag the overflow and drop back to idle.
          r.fault      = bvs_pkg::FAULT_DEPTH;
          r.value_done = 1'b1;
          open_cnt     = 0;
          scan_mode    = bvs_pkg::MODE_IDLE;
        end else begin
          open_cnt++;
        end
      end
      bvs_pkg::MODE_LEN: begin
        if (dec_byte) begin
          r.byte_role = bvs_pkg::ROLE_DIGIT;
          if (len_left > (LEN_MAX - d) / 64'd10) begin
            len_left = LEN_MAX;
            r.fault  = bvs_pkg::FAULT_LEN;
          end else begin
            len_left = len_left * 64'd10 + d;
          end
        end else begin
          // Whatever ends the digits is the separator.
          r.byte_role = bvs_pkg::ROLE_SEP;
          scan_mode   = (len_left == 64'd0) ? bvs_pkg::MODE_ELEM : bvs_pkg::MODE_STR;
        end
      end
      bvs_pkg::MODE_STR: begin
        r.byte_role = bvs_pkg::ROLE_STR;
        if (len_left > 64'd0) len_left--;
        if (len_left == 64'd0) scan_mode = bvs_pkg::MODE_ELEM;
      end
      bvs_pkg::MODE_INT: begin
        r.byte_role = bvs_pkg::ROLE_INT;
        if (b == bvs_pkg::CHAR_E) scan_mode = bvs_pkg::MODE_ELEM;
      end
      default: begin
        // Any byte taken while idle opens the outer container.
        open_cnt  = 1;
        len_left  = 64'd0;
        scan_mode = bvs_pkg::MODE_ELEM;
      end
    endcase
    r.nest_level = open_cnt[6:0];
    byte_verdicts.push_back(r);
  endfunction

  // Append a decimal length, now and then with a leading zero.
  function automatic void add_length(input logic [63:0] n, input bit pad);
    string s;
    s = $sformatf("%0d", n);
    if (pad && $urandom_range(0, 9) == 0) stream_q.push_back(bvs_pkg::CHAR_ZERO);
    for (int k = 0; k < s.len(); k++) stream_q.push_back(s[k]);
  endfunction

  function automatic void add_string();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 12);
    add_length(64'(n), 1'b1);
    stream_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CHAR_COLON);
    repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_integer();
    logic [7:0] b;
    stream_q.push_back(bvs_pkg::CHAR_I);
    repeat ($urandom_range(0, 6)) begin
      b = 8'($urandom_range(0, 255));
      if (b == bvs_pkg::CHAR_E) b = 8'h2D;
      stream_q.push_back(b);
    end
    stream_q.push_back(bvs_pkg::CHAR_E);
  endfunction

  // Append a container (list, dictionary or one opened by another byte) with random content.
  function automatic void add_container(input int depth, input bit top);
    logic [7:0] b;
    if (top && $urandom_range(0, 3) == 0) begin
      b = 8'($urandom_range(0, 255));
    end else if ($urandom_range(0, 3) != 0) begin
      b = $urandom_range(0, 1) ? bvs_pkg::CHAR_L : CHAR_D;
    end else begin
      b = 8'($urandom_range(1, 255));
      while ((b >= bvs_pkg::CHAR_ZERO && b <= bvs_pkg::CHAR_NINE) ||
             b == bvs_pkg::CHAR_I || b == bvs_pkg::CHAR_E)
        b = 8'($urandom_range(1, 255));
    end
    stream_q.push_back(b);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, (depth < 5) ? 2 : 1))
        0: add_string();
        1: add_integer();
        default: add_container(depth + 1, 1'b0);
      endcase
    end
    stream_q.push_back(bvs_pkg::CHAR_E);
  endfunction

  // Wait until every queued byte has been taken by the block.
  task automatic drain_stream();
    do @(negedge clk); while (stream_q.size() != 0 || src_valid);
  endtask

  // Feed bytes until the scan sits at an element start inside a container.
  task automatic settle_at_element();
    while (scan_mode != bvs_pkg::MODE_ELEM) begin
      case (scan_mode)
        bvs_pkg::MODE_IDLE: stream_q.push_back(bvs_pkg::CHAR_L);
        bvs_pkg::MODE_LEN:  stream_q.push_back(CHAR_COLON);
        bvs_pkg::MODE_INT:  stream_q.push_back(bvs_pkg::CHAR_E);
        default: for (int k = 0; k < int'(len_left); k++) stream_q.push_back(8'h61);
      endcase
      drain_stream();
    end
  endtask

  // Take bytes: a request is accepted at a rising edge with valid and ready high.
  always @(posedge clk) begin
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= src_valid && byte_chan.ready;
      if (src_valid && byte_chan.ready) begin
        scan_byte(src_byte);
        void'(stream_q.pop_front());
        bytes_sent++;
      end
    end
  end

  // Drive the next byte at the falling edge. Hold valid across a stall, drop it after
  // an accepted request for a random gap, and skip gaps entirely in quiet stretches.
  always @(negedge clk) begin
    if (!rst) begin
      nxt_valid = src_valid;
      if (byte_taken) begin
        nxt_valid = 1'b0;
        src_gap   = (((bytes_sent / 150) % 4) == 3) ? 0 : $urandom_range(0, 3);
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (stream_q.size() != 0) begin
          nxt_valid = 1'b1;
          src_byte <= stream_q[0];
        end
      end
      src_valid <= nxt_valid;
    end
  end

  // Set result ready at the falling edge: a random stall after each accepted result,
  // and once a long hold-off so the block backs up and stalls its input.
  always @(negedge clk) begin
    if (!rst) begin
      if (res_taken) begin
        sink_stall = (((verdicts_seen / 150) % 4) == 1) ? 0 : $urandom_range(0, 3);
        if (verdicts_seen == HOLD_AT) sink_hold = HOLD_LEN;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        sink_ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Check each accepted result against the oldest verdict, field by field.
  always @(posedge clk) begin
    if (rst) begin
      res_taken <= 1'b0;
    end else begin
      res_taken <= result_chan.valid && sink_ready;
      if (result_chan.valid && sink_ready) begin
        verdicts_seen++;
        if (byte_verdicts.size() == 0) begin
          $error("result with no byte outstanding");
          errors++;
        end else begin
          want = byte_verdicts.pop_front();
          if (result_chan.value_done !== want.value_done) begin
            $error("value_done: expected %0d, got %0d", want.value_done,
                   result_chan.value_done);
            errors++;
          end
          if (result_chan.nest_level !== want.nest_level) begin
            $error("nest_level: expected %0d, got %0d", want.nest_level,
                   result_chan.nest_level);
            errors++;
          end
          if (result_chan.byte_role !== want.byte_role) begin
            $error("byte_role: expected %0d, got %0d", want.byte_role,
                   result_chan.byte_role);
            errors++;
          end
          if (result_chan.fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, result_chan.fault);
            errors++;
          end
        end
      end
    end
  end

  // Bound the run in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic [7:0] warmup [20];
    int         pick;
    int         mark;
    int         keep;
    int         n_directed;

    scan_mode = bvs_pkg::MODE_IDLE;
    open_cnt  = 0;
    len_left  = 64'd0;

    // Directed opening: NUL opening from idle, empty string, integer with NUL and 0xFF,
    // string with an odd separator and NUL content, nested opens by 'l' and 0xFF,
    // NUL stop at element start, and 'e' taken while idle.
    warmup = '{bvs_pkg::CHAR_NUL, bvs_pkg::CHAR_ZERO, CHAR_COLON, bvs_pkg::CHAR_I,
               bvs_pkg::CHAR_NUL, 8'hFF, bvs_pkg::CHAR_E,
               8'h32, 8'hFF, bvs_pkg::CHAR_NUL, bvs_pkg::CHAR_E, bvs_pkg::CHAR_L, 8'hFF,
               bvs_pkg::CHAR_E, bvs_pkg::CHAR_E, bvs_pkg::CHAR_E,
               CHAR_D, bvs_pkg::CHAR_NUL, bvs_pkg::CHAR_E, bvs_pkg::CHAR_E};
    foreach (warmup[k]) stream_q.push_back(warmup[k]);
    n_directed = stream_q.size();

    // Random part: mostly well-formed values, with noise, truncated values and
    // early NUL stops mixed in.
    while (stream_q.size() < n_directed + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        add_container(0, 1'b1);
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        mark = stream_q.size();
        add_container(0, 1'b1);
        keep = $urandom_range(1, stream_q.size() - mark - 1);
        while (stream_q.size() > mark + keep) void'(stream_q.pop_back());
      end else begin
        stream_q.push_back(bvs_pkg::CHAR_L);
        if ($urandom_range(0, 1)) add_string();
        stream_q.push_back(bvs_pkg::CHAR_NUL);
      end
    end

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    drain_stream();

    // Nest to exactly DEPTH_MAX and close everything back down.
    settle_at_element();
    repeat (DEPTH_MAX - open_cnt) stream_q.push_back(bvs_pkg::CHAR_L);
    add_integer();
    repeat (DEPTH_MAX) stream_q.push_back(bvs_pkg::CHAR_E);
    drain_stream();

    // From idle, open one container past DEPTH_MAX.
    repeat (DEPTH_MAX + 1) stream_q.push_back(bvs_pkg::CHAR_L);
    drain_stream();

    // Build the largest length, push it past saturation, then a few string bytes.
    settle_at_element();
    add_length(LEN_MAX, 1'b0);
    stream_q.push_back(8'h37);
    stream_q.push_back(bvs_pkg::CHAR_ZERO);
    stream_q.push_back(CHAR_COLON);
    repeat (3) stream_q.push_back(8'($urandom_range(0, 255)));
    drain_stream();

    // Wait for every verdict, then keep waiting for anything stray.
    while (byte_verdicts.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (errors == 0 && byte_verdicts.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
